/* rtl/core/glyph_atlas_shelf_cache_assert.svh */
// Assertion helpers used by the top-level cache module.
`ifndef GLYPH_ATLAS_SHELF_CACHE_ASSERT_SVH
`define GLYPH_ATLAS_SHELF_CACHE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GASC_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GASC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* rtl/core/gasc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gasc_pkg;

  // Table geometry
  localparam int MAX_GLYPHS = 256;
  localparam int SLOT_AW    = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
  localparam int CNT_W      = $clog2(MAX_GLYPHS + 1);

  // Packer constants
  localparam logic [13:0] PAD        = 14'd2;
  localparam logic [11:0] CURSOR_MAX = 12'd4095;

  // Register indexes
  localparam logic REG_ATLAS_WIDTH  = 1'b0;
  localparam logic REG_ATLAS_HEIGHT = 1'b1;

  // Stored entry payload: {oy, ox, h, w, y, x}
  localparam int ENTRY_W = 72;

  typedef enum logic [1:0] {
    ST_HIT        = 2'd0,
    ST_PLACED     = 2'd1,
    ST_ATLAS_FULL = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRAP,
    S_FIT,
    S_EMIT
  } state_t;

  // Control from sequencer to packer
  typedef struct packed {
    logic wrap_step;
    logic fit_step;
  } pk_ctrl_t;

  // Packer outcome for the fit step
  typedef struct packed {
    logic             atlas_full;
    logic             table_full;
    logic [CNT_W-1:0] slot;
    logic [11:0]      px;
    logic [11:0]      py;
  } pk_res_t;

  function automatic logic [11:0] sat_cursor(input logic [13:0] v);
    logic [11:0] r;
    if (v > {2'b00, CURSOR_MAX}) r = CURSOR_MAX;
    else r = v[11:0];
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/gasc_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none

// Lookup request item
interface gasc_req_if;
  logic               valid;
  logic               ready;
  logic [15:0]        glyph_code;
  logic [11:0]        raster_width;
  logic [11:0]        raster_height;
  logic signed [11:0] raster_offset_x;
  logic signed [11:0] raster_offset_y;

  modport source (output valid, glyph_code, raster_width, raster_height,
                  raster_offset_x, raster_offset_y, input ready);
  modport sink (input valid, glyph_code, raster_width, raster_height,
                raster_offset_x, raster_offset_y, output ready);
endinterface

// Placement result item
interface gasc_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [7:0]         slot_index;
  logic [11:0]        place_x;
  logic [11:0]        place_y;
  logic [11:0]        placed_width;
  logic [11:0]        placed_height;
  logic signed [11:0] placed_offset_x;
  logic signed [11:0] placed_offset_y;

  modport source (output valid, status, slot_index, place_x, place_y, placed_width,
                  placed_height, placed_offset_x, placed_offset_y, input ready);
  modport sink (input valid, status, slot_index, place_x, place_y, placed_width,
                placed_height, placed_offset_x, placed_offset_y, output ready);
endinterface

`default_nettype wire

/* rtl/core/gasc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, registered read
module gasc_ram #(
  parameter int DW = 16,
  parameter int AW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/gasc_packer.sv */
`timescale 1ns / 1ps
`default_nettype none

// Shelf packer: cursor, row height and fill count
module gasc_packer (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire gasc_pkg::pk_ctrl_t         ctrl,
  input  wire logic [11:0]                width,
  input  wire logic [11:0]                height,
  input  wire logic [12:0]                sheet_width,
  input  wire logic [12:0]                sheet_height,
  output gasc_pkg::pk_res_t               res,
  output logic [gasc_pkg::CNT_W-1:0]      count
);

  logic [11:0] cursor_x;
  logic [11:0] cursor_y;
  logic [11:0] row_height;
  logic [13:0] x_end;
  logic [13:0] y_wrap;
  logic [13:0] y_end;
  logic        wrap;
  logic        commit;

  // Extents at the current cursor
  assign x_end  = {2'b00, cursor_x} + {2'b00, width} + gasc_pkg::PAD;
  assign y_wrap = {2'b00, cursor_y} + {2'b00, row_height} + gasc_pkg::PAD;
  assign y_end  = {2'b00, cursor_y} + {2'b00, height} + gasc_pkg::PAD;
  assign wrap   = x_end >= {1'b0, sheet_width};

  // Fit outcome
  always_comb begin
    res.atlas_full = y_end >= {1'b0, sheet_height};
    res.table_full = count >= gasc_pkg::CNT_W'(gasc_pkg::MAX_GLYPHS);
    res.slot       = count;
    res.px         = cursor_x;
    res.py         = cursor_y;
  end

  assign commit = ctrl.fit_step && !res.atlas_full && !res.table_full;

  // Cursor and count update; a wrap is kept even if the fit fails
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x   <= 12'd1;
      cursor_y   <= 12'd1;
      row_height <= 12'd0;
      count      <= '0;
    end else if (ctrl.wrap_step && wrap) begin
      cursor_x   <= 12'd1;
      cursor_y   <= gasc_pkg::sat_cursor(y_wrap);
      row_height <= 12'd0;
    end else if (commit) begin
      cursor_x <= gasc_pkg::sat_cursor(x_end);
      count    <= count + gasc_pkg::CNT_W'(1);
      if (height > row_height) begin
        row_height <= height;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/glyph_atlas_shelf_cache.sv */
// Channel  Role   Payload
// -------  -----  --------------------------------------------------------
// req      sink   glyph_code, raster_width/height, raster_offset_x/y
// rsp      source status, slot_index, place_x/y, placed_width/height/offset
// cfg      write  cfg_index selects sheet width (0) or sheet height (1)
//
// One item at a time. On a miss the code memory is read one entry per cycle in
// insertion order (skipped with an empty table), then come the wrap, fit and
// emit cycles, and emit loads the result register. A hit on any entry ends the
// walk early and goes straight to emit. A waiting result stalls only the emit
// cycle of the next item, which can be accepted the cycle after the result is
// loaded. Synchronous reset clears count, cursor and handshake state, not the entry memories.
`timescale 1ns / 1ps
`default_nettype none

`include "glyph_atlas_shelf_cache_assert.svh"

module glyph_atlas_shelf_cache (
  input  wire logic        clk,
  input  wire logic        rst,
  gasc_req_if.sink         req,
  gasc_rsp_if.source       rsp,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_data
);

  localparam int AW = gasc_pkg::SLOT_AW;
  localparam int CW = gasc_pkg::CNT_W;

  gasc_pkg::state_t   state, state_next;
  gasc_pkg::pk_ctrl_t pk_ctrl;
  gasc_pkg::pk_res_t  pk_res;

  logic [12:0] sheet_width;
  logic [12:0] sheet_height;

  // Latched request
  logic [15:0] req_code;
  logic [11:0] req_w;
  logic [11:0] req_h;
  logic [11:0] req_ox;
  logic [11:0] req_oy;

  // Scan pipeline
  logic [CW-1:0] scan_idx;
  logic          chk_valid;
  logic [AW-1:0] chk_idx;
  logic          chk_last;
  logic [CW-1:0] count;

  // Memory ports
  logic                          mem_we;
  logic [AW-1:0]                 mem_raddr;
  logic [15:0]                   rd_code;
  logic [gasc_pkg::ENTRY_W-1:0]  rd_entry;
  logic [gasc_pkg::ENTRY_W-1:0]  wr_entry;

  // Control
  logic accept;
  logic issue_en;
  logic hit;
  logic scan_end;
  logic emit_load;

  // Staged result
  gasc_pkg::status_t res_status;
  logic [7:0]        res_slot;
  logic [11:0]       res_px;
  logic [11:0]       res_py;
  logic [11:0]       res_w;
  logic [11:0]       res_h;
  logic [11:0]       res_ox;
  logic [11:0]       res_oy;

  // Output register
  logic              out_valid;
  logic [1:0]        out_status;
  logic [7:0]        out_slot;
  logic [11:0]       out_px;
  logic [11:0]       out_py;
  logic [11:0]       out_w;
  logic [11:0]       out_h;
  logic [11:0]       out_ox;
  logic [11:0]       out_oy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sheet_width  <= 13'd2048;
      sheet_height <= 13'd2048;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gasc_pkg::REG_ATLAS_WIDTH:  sheet_width  <= cfg_data;
        gasc_pkg::REG_ATLAS_HEIGHT: sheet_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Entry memories
  assign mem_raddr = scan_idx[AW-1:0];
  assign wr_entry  = {req_oy, req_ox, req_h, req_w, pk_res.py, pk_res.px};

  gasc_ram #(.DW(16), .AW(AW)) u_code_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[AW-1:0]),
    .wdata (req_code),
    .raddr (mem_raddr),
    .rdata (rd_code)
  );

  gasc_ram #(.DW(gasc_pkg::ENTRY_W), .AW(AW)) u_entry_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count[AW-1:0]),
    .wdata (wr_entry),
    .raddr (mem_raddr),
    .rdata (rd_entry)
  );

  gasc_packer u_packer (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (pk_ctrl),
    .width        (req_w),
    .height       (req_h),
    .sheet_width  (sheet_width),
    .sheet_height (sheet_height),
    .res          (pk_res),
    .count        (count)
  );

  // Sequencer outputs
  always_comb begin
    req.ready         = (state == gasc_pkg::S_IDLE);
    issue_en          = (state == gasc_pkg::S_SCAN) && (scan_idx < count);
    hit               = (state == gasc_pkg::S_SCAN) && chk_valid && (rd_code == req_code);
    scan_end          = chk_valid && chk_last;
    pk_ctrl.wrap_step = (state == gasc_pkg::S_WRAP);
    pk_ctrl.fit_step  = (state == gasc_pkg::S_FIT);
    mem_we            = pk_ctrl.fit_step && !pk_res.atlas_full && !pk_res.table_full;
    emit_load         = (state == gasc_pkg::S_EMIT) && (!out_valid || rsp.ready);
  end

  assign accept = req.valid && req.ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gasc_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (count == '0) ? gasc_pkg::S_WRAP : gasc_pkg::S_SCAN;
        end
      end
      gasc_pkg::S_SCAN: begin
        if (hit) begin
          state_next = gasc_pkg::S_EMIT;
        end else if (scan_end) begin
          state_next = gasc_pkg::S_WRAP;
        end
      end
      gasc_pkg::S_WRAP: state_next = gasc_pkg::S_FIT;
      gasc_pkg::S_FIT:  state_next = gasc_pkg::S_EMIT;
      gasc_pkg::S_EMIT: begin
        if (emit_load) begin
          state_next = gasc_pkg::S_IDLE;
        end
      end
      default: state_next = gasc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gasc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (accept) begin
      req_code <= req.glyph_code;
      req_w    <= req.raster_width;
      req_h    <= req.raster_height;
      req_ox   <= req.raster_offset_x;
      req_oy   <= req.raster_offset_y;
    end
  end

  // Scan address and compare pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx  <= '0;
      chk_valid <= 1'b0;
    end else if (accept) begin
      scan_idx  <= '0;
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= issue_en;
      if (issue_en) begin
        scan_idx <= scan_idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx  <= scan_idx[AW-1:0];
    chk_last <= (scan_idx + CW'(1)) == count;
  end

  // Result staging
  always_ff @(posedge clk) begin
    if (hit) begin
      res_status <= gasc_pkg::ST_HIT;
      res_slot   <= 8'(chk_idx);
      res_px     <= rd_entry[11:0];
      res_py     <= rd_entry[23:12];
      res_w      <= rd_entry[35:24];
      res_h      <= rd_entry[47:36];
      res_ox     <= rd_entry[59:48];
      res_oy     <= rd_entry[71:60];
    end else if (pk_ctrl.fit_step) begin
      if (pk_res.atlas_full || pk_res.table_full) begin
        res_status <= pk_res.atlas_full ? gasc_pkg::ST_ATLAS_FULL
                                        : gasc_pkg::ST_TABLE_FULL;
        res_slot   <= '0;
        res_px     <= '0;
        res_py     <= '0;
        res_w      <= '0;
        res_h      <= '0;
        res_ox     <= '0;
        res_oy     <= '0;
      end else begin
        res_status <= gasc_pkg::ST_PLACED;
        res_slot   <= 8'(pk_res.slot);
        res_px     <= pk_res.px;
        res_py     <= pk_res.py;
        res_w      <= req_w;
        res_h      <= req_h;
        res_ox     <= req_ox;
        res_oy     <= req_oy;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_px     <= res_px;
      out_py     <= res_py;
      out_w      <= res_w;
      out_h      <= res_h;
      out_ox     <= res_ox;
      out_oy     <= res_oy;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.slot_index      = out_slot;
  assign rsp.place_x         = out_px;
  assign rsp.place_y         = out_py;
  assign rsp.placed_width    = out_w;
  assign rsp.placed_height   = out_h;
  assign rsp.placed_offset_x = out_ox;
  assign rsp.placed_offset_y = out_oy;

  // Checks
  `GASC_ASSERT_NOW(a_count_bound, clk, rst, 1'b1,
    count <= CW'(gasc_pkg::MAX_GLYPHS), "entry count beyond table size")
  `GASC_ASSERT_NOW(a_hit_in_table, clk, rst, hit,
    {1'b0, chk_idx} < {1'b0, count}, "hit on an entry beyond the count")
  `GASC_ASSERT_NEXT(a_place_counts, clk, rst, mem_we,
    count == $past(count) + CW'(1), "placement did not advance the count")

endmodule

`default_nettype wire
